### hw/rtl/fixed_point_exp_negative_q12_assert.svh
// Assertion shorthands for the exp pipeline; clk and rst_n come from the using module.
`ifndef FIXED_POINT_EXP_NEGATIVE_Q12_ASSERT_SVH
`define FIXED_POINT_EXP_NEGATIVE_Q12_ASSERT_SVH

// Same-cycle implication.
`define FPE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication.
`define FPE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

### hw/rtl/fpe_pkg.sv
package fpe_pkg;

    localparam int XW        = 32;  // argument width
    localparam int EW        = 13;  // result width
    localparam int Q12_SHIFT = 12;
    localparam int FW        = 12;  // fraction of the scaled argument
    localparam int PW        = 13;  // polynomial accumulator
    localparam int AW        = 16;  // magnitude of an in-range argument
    localparam int MW        = 29;  // magnitude times log2(e)
    localparam int YW        = 17;  // magnitude of the scaled argument
    localparam int SW        = 5;   // final shift amount, 1 to 18
    localparam int ROUND_UP  = 4095;
    localparam int HALF_STEP = 2048;

    localparam logic [EW-1:0]        Q12_ONE     = 13'd4096;
    localparam logic signed [XW-1:0] LOWER_BOUND = -32'sd49152;
    localparam logic [12:0]          LOG2E_Q12   = 13'd5909;
    localparam logic [PW-1:0]        HORNER_SEED = 13'd5;

    localparam int NUM_COEF = 5;
    localparam logic [PW-1:0] HORNER_COEF [NUM_COEF] =
        '{13'd39, 13'd227, 13'd984, 13'd2839, 13'd4096};

    // multiply, split, one stage per remaining coefficient, final shift
    localparam int NUM_STAGES = NUM_COEF + 2;
    localparam int LAST       = NUM_STAGES - 1;

    typedef struct packed {
        logic          pos;   // argument is zero or positive
        logic          deep;  // argument at or below -12.0
        logic [MW-1:0] m;
        logic [FW-1:0] f;
        logic [SW-1:0] sh;
        logic [PW-1:0] p;
    } fpe_stage_t;

    // One Horner step: round(p * f / 4096) + c
    function automatic logic [PW-1:0] horner_step(input logic [PW-1:0] p,
                                                  input logic [FW-1:0] f,
                                                  input logic [PW-1:0] c);
        logic [PW+FW-1:0] prod;
        logic [PW+FW-1:0] rnd;
        prod = (PW+FW)'(p) * (PW+FW)'(f);
        rnd  = (prod + (PW+FW)'(HALF_STEP)) >> Q12_SHIFT;
        return PW'(rnd) + c;
    endfunction

endpackage

### hw/rtl/fpe_in_if.sv
interface fpe_in_if import fpe_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [XW-1:0] x_q12;

    modport source (output valid, output x_q12, input ready);
    modport sink (input valid, input x_q12, output ready);
endinterface

### hw/rtl/fpe_out_if.sv
interface fpe_out_if import fpe_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [EW-1:0] exp_q12;

    modport source (output valid, output exp_q12, input ready);
    modport sink (input valid, input exp_q12, output ready);
endinterface

### hw/rtl/fixed_point_exp_negative_q12.sv
// exp(x) for a signed Q12 argument, result in unsigned Q12 (4096 is one). A seven-stage
// pipeline: one stage scales the argument by log2(e), one splits it into shift and fraction
// and starts the Horner polynomial, four stages finish the polynomial with one 13x12
// multiplier each, and the last applies the shift and the saturation cases. An item enters
// every cycle unless an output stall has backed up to stage 0; results leave the last stage. A stalled
// output holds the pipeline in place, and empty stages still fill while it waits.
`include "fixed_point_exp_negative_q12_assert.svh"

module fixed_point_exp_negative_q12
    import fpe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    fpe_in_if.sink     din,
    fpe_out_if.source  dout
);

    fpe_stage_t            st_reg  [NUM_STAGES];
    fpe_stage_t            st_next [NUM_STAGES];
    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] v_next;
    logic [NUM_STAGES-1:0] rdy;

    // A stage loads when it is empty or its successor loads.
    always_comb
    begin
        rdy[LAST] = !v_reg[LAST] || dout.ready;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
        v_next[0] = din.valid;
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            v_next[i] = v_reg[i-1];
        end
    end

    assign din.ready    = rdy[0];
    assign dout.valid   = v_reg[LAST];
    assign dout.exp_q12 = st_reg[LAST].p;

    always_comb
    begin
        logic [AW-1:0] ax;
        logic [MW:0]   msum;
        logic [YW-1:0] yn;
        logic [YW:0]   shsum;
        logic [PW-1:0] shifted;

        // Stage 0: flags and magnitude times log2(e)
        st_next[0]      = st_reg[0];
        ax              = AW'(~din.x_q12[AW-1:0]) + AW'(1);
        st_next[0].pos  = !din.x_q12[XW-1];
        st_next[0].deep = din.x_q12 <= LOWER_BOUND;
        st_next[0].m    = MW'(ax) * MW'(LOG2E_Q12);

        // Stage 1: y = -ceil(m / 4096); fraction is y mod 4096, shift is -floor(y / 4096)
        st_next[1]    = st_reg[0];
        msum          = {1'b0, st_reg[0].m} + (MW+1)'(ROUND_UP);
        yn            = YW'(msum >> Q12_SHIFT);
        shsum         = {1'b0, yn} + (YW+1)'(ROUND_UP);
        st_next[1].f  = FW'(YW'(0) - yn);
        st_next[1].sh = SW'(shsum >> Q12_SHIFT);
        st_next[1].p  = horner_step(HORNER_SEED, FW'(YW'(0) - yn), HORNER_COEF[0]);

        // Remaining Horner steps, one coefficient per stage
        for (int j = 2; j <= NUM_COEF; j++)
        begin
            st_next[j]   = st_reg[j-1];
            st_next[j].p = horner_step(st_reg[j-1].p, st_reg[j-1].f, HORNER_COEF[j-1]);
        end

        // Last stage: scale down by the integer part, apply saturation
        st_next[LAST] = st_reg[LAST-1];
        shifted       = st_reg[LAST-1].p >> st_reg[LAST-1].sh;
        if (st_reg[LAST-1].pos)
        begin
            st_next[LAST].p = PW'(Q12_ONE);
        end
        else if (st_reg[LAST-1].deep)
        begin
            st_next[LAST].p = '0;
        end
        else
        begin
            st_next[LAST].p = shifted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            if (rdy[i] && v_next[i])
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    `FPE_ASSERT_IMPL(a_out_range, dout.valid, dout.exp_q12 <= Q12_ONE)
    `FPE_ASSERT_IMPL(a_drain_ready, !v_reg[LAST], din.ready)

    for (genvar g = 0; g < NUM_STAGES; g++)
    begin : g_hold
        `FPE_ASSERT_NEXT(a_stage_hold, v_reg[g] && !rdy[g], v_reg[g] && $stable(st_reg[g]))
    end

endmodule
